// ----- rtl/core/dlrs_pkg.sv -----
// ----------------------------------------------------------------------------
// dlrs_pkg
// Shared types, codes and fixed-point helpers of the dense layer block.
// ----------------------------------------------------------------------------
`default_nettype none

package dlrs_pkg;

    localparam int DEF_NUM_IN  = 64;
    localparam int DEF_NUM_OUT = 16;
    localparam int QDEPTH      = 4;

    localparam logic [2:0] OP_WEIGHT = 3'd0;
    localparam logic [2:0] OP_BIAS   = 3'd1;
    localparam logic [2:0] OP_FWD    = 3'd2;
    localparam logic [2:0] OP_GRAD   = 3'd3;
    localparam logic [2:0] OP_STEP   = 3'd4;

    localparam logic KIND_FWD  = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    localparam logic CFG_RELU = 1'b0;
    localparam logic CFG_LR   = 1'b1;

    localparam logic        RELU_RESET = 1'b1;
    localparam logic [31:0] LR_RESET   = 32'd429497;

    typedef enum logic [2:0] {
        CMD_WEIGHT,
        CMD_BIAS,
        CMD_FWD,
        CMD_GRAD,
        CMD_STEP
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [5:0]         out_index;
        logic [5:0]         in_index;
        logic signed [31:0] data_value;
        logic               last_element;
        logic               o_ok;
        logic               i_ok;
    } dlrs_entry_t;

    typedef struct packed {
        logic        valid;
        dlrs_entry_t entry;
    } dlrs_head_t;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Q32.32 product to Q16.16, round half up
    function automatic logic signed [63:0] qround(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t >>> 16;
    endfunction

    // param minus signed step of |acc| * lr, rounded half away from zero
    function automatic logic signed [31:0] sgd_upd(input logic signed [31:0] param,
                                                   input logic [63:0] prod,
                                                   input logic neg);
        logic [63:0]        t;
        logic signed [34:0] delta;
        logic signed [34:0] diff;
        t     = prod + 64'h80000000;
        delta = $signed({3'b000, t[63:32]});
        if (neg)
            delta = -delta;
        diff = $signed({{3{param[31]}}, param}) - delta;
        return clamp32({{29{diff[34]}}, diff});
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dlrs_item_if.sv -----
// ----------------------------------------------------------------------------
// dlrs_item_if
// Input item channel: valid/ready with the item fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlrs_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [5:0]         out_index;
    logic [5:0]         in_index;
    logic signed [31:0] data_value;
    logic               last_element;

    modport source (output valid, operation, out_index, in_index, data_value,
                    last_element, input ready);
    modport sink   (input valid, operation, out_index, in_index, data_value,
                    last_element, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dlrs_result_if.sv -----
// ----------------------------------------------------------------------------
// dlrs_result_if
// Result channel: valid/ready with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlrs_result_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [5:0]         result_index;
    logic signed [31:0] result_value;
    logic               result_last;

    modport source (output valid, result_kind, result_index, result_value,
                    result_last, input ready);
    modport sink   (input valid, result_kind, result_index, result_value,
                    result_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dlrs_front.sv -----
// ----------------------------------------------------------------------------
// dlrs_front
// Accepts items, decodes and range-checks them; queues known ops for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dlrs_front
    import dlrs_pkg::*;
#(
    parameter int NUM_IN  = DEF_NUM_IN,
    parameter int NUM_OUT = DEF_NUM_OUT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dlrs_item_if.sink   item,
    input  wire logic   enable,
    input  wire logic   pop,
    output dlrs_head_t  head
);

    localparam int PW = $clog2(QDEPTH);

    dlrs_entry_t      fifo_mem [QDEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             push;
    logic             known_op;
    dlrs_entry_t      dec;

    assign item.ready = enable && (count_reg != (PW+1)'(QDEPTH));

    always_comb
    begin
        known_op = 1'b1;
        dec.cmd  = CMD_WEIGHT;
        case (item.operation)
            OP_WEIGHT: dec.cmd = CMD_WEIGHT;
            OP_BIAS:   dec.cmd = CMD_BIAS;
            OP_FWD:    dec.cmd = CMD_FWD;
            OP_GRAD:   dec.cmd = CMD_GRAD;
            OP_STEP:   dec.cmd = CMD_STEP;
            default:   known_op = 1'b0;
        endcase
        dec.out_index    = item.out_index;
        dec.in_index     = item.in_index;
        dec.data_value   = item.data_value;
        dec.last_element = item.last_element;
        dec.o_ok         = 32'(item.out_index) < NUM_OUT;
        dec.i_ok         = 32'(item.in_index) < NUM_IN;
    end

    assign push       = item.valid && item.ready && known_op;
    assign head.valid = (count_reg != '0);
    assign head.entry = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dlrs_back.sv -----
// ----------------------------------------------------------------------------
// dlrs_back
// Sequencer with one shared multiplier over the weight, bias, input, gradient
// and accumulator memories; drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dlrs_back
    import dlrs_pkg::*;
#(
    parameter int NUM_IN  = DEF_NUM_IN,
    parameter int NUM_OUT = DEF_NUM_OUT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  dlrs_head_t       head,
    output logic             pop,
    output logic             clear_done,
    input  wire logic        relu_enable,
    input  wire logic [31:0] learning_rate,
    dlrs_result_if.source    rslt
);

    localparam int NW = NUM_OUT * NUM_IN;
    localparam int OW = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;
    localparam int IW = (NUM_IN > 1) ? $clog2(NUM_IN) : 1;
    localparam int KW = (NW > 1) ? $clog2(NW) : 1;
    localparam logic [OW-1:0] A_LAST = OW'(NUM_OUT - 1);
    localparam logic [IW-1:0] B_LAST = IW'(NUM_IN - 1);
    localparam logic [KW-1:0] K_LAST = KW'(NW - 1);
    localparam logic [KW-1:0] K_STEP = KW'(NUM_IN);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE,
        ST_F_BIAS, ST_F_BLD, ST_F_RD, ST_F_MUL, ST_F_ACC, ST_F_OUT,
        ST_G_RD, ST_G_BW, ST_G_XRD, ST_G_MUL, ST_G_ACC,
        ST_H_RD, ST_H_MUL, ST_H_ACC, ST_H_OUT,
        ST_S_RD, ST_S_MUL, ST_S_WR,
        ST_T_RD, ST_T_MUL, ST_T_WR
    } state_t;

    state_t             state_reg, state_next;
    logic [OW-1:0]      a_reg, a_next;
    logic [IW-1:0]      b_reg, b_next;
    logic [KW-1:0]      k_reg, k_next;
    logic signed [63:0] sum_reg, sum_next;
    logic signed [31:0] g_hold_reg, g_hold_next;
    logic signed [63:0] prod_reg;
    logic               neg_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [5:0]         out_index_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;
    logic               out_load;
    logic               out_kind_d;
    logic [5:0]         out_index_d;
    logic signed [31:0] out_value_d;
    logic               out_last_d;
    logic               out_free;

    logic signed [31:0] w_mem    [NW];
    logic signed [31:0] wacc_mem [NW];
    logic signed [31:0] bias_mem [NUM_OUT];
    logic signed [31:0] bacc_mem [NUM_OUT];
    logic signed [31:0] g_mem    [NUM_OUT];
    logic signed [31:0] x_mem    [NUM_IN];

    logic signed [31:0] w_rd, wacc_rd, bias_rd, bacc_rd, g_rd, x_rd;

    logic               w_we, wacc_we, bias_we, bacc_we, g_we, x_we;
    logic [KW-1:0]      w_wa;
    logic [OW-1:0]      bias_wa, bacc_wa;
    logic signed [31:0] w_wd, wacc_wd, bias_wd, bacc_wd;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic               mul_neg;
    logic signed [32:0] acc_sel;
    logic signed [63:0] rounded;
    logic signed [31:0] fwd_val;

    dlrs_entry_t        e;

    assign e        = head.entry;
    assign out_free = !out_valid_reg || rslt.ready;
    assign rounded  = qround(prod_reg);

    always_comb
    begin
        fwd_val = clamp32(sum_reg);
        if (relu_enable && fwd_val < 0)
            fwd_val = '0;
    end

    // memories: read address held in counters, registered read data
    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_wa] <= w_wd;
        w_rd <= w_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wacc_we)
            wacc_mem[k_reg] <= wacc_wd;
        wacc_rd <= wacc_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (bias_we)
            bias_mem[bias_wa] <= bias_wd;
        bias_rd <= bias_mem[a_reg];
    end

    always_ff @(posedge clk)
    begin
        if (bacc_we)
            bacc_mem[bacc_wa] <= bacc_wd;
        bacc_rd <= bacc_mem[a_reg];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            g_mem[e.out_index[OW-1:0]] <= e.data_value;
        g_rd <= g_mem[a_reg];
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[e.in_index[IW-1:0]] <= e.data_value;
        x_rd <= x_mem[b_reg];
    end

    // shared multiplier
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        acc_sel = {bacc_rd[31], bacc_rd};
        if (state_reg == ST_S_MUL)
            acc_sel = {wacc_rd[31], wacc_rd};
        case (state_reg)
            ST_F_MUL:
            begin
                mul_a = {w_rd[31], w_rd};
                mul_b = {x_rd[31], x_rd};
            end
            ST_G_MUL:
            begin
                mul_a = {g_hold_reg[31], g_hold_reg};
                mul_b = {x_rd[31], x_rd};
            end
            ST_H_MUL:
            begin
                mul_a = {g_rd[31], g_rd};
                mul_b = {w_rd[31], w_rd};
            end
            ST_S_MUL, ST_T_MUL:
            begin
                mul_neg = acc_sel[32];
                mul_a   = mul_neg ? -acc_sel : acc_sel;
                mul_b   = $signed({1'b0, learning_rate});
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[63:0];
        neg_reg  <= mul_neg;
    end

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        sum_next    = sum_reg;
        g_hold_next = g_hold_reg;
        pop         = 1'b0;
        w_we        = 1'b0;
        w_wa        = k_reg;
        w_wd        = sgd_upd(w_rd, prod_reg, neg_reg);
        wacc_we     = 1'b0;
        wacc_wd     = '0;
        bias_we     = 1'b0;
        bias_wa     = a_reg;
        bias_wd     = sgd_upd(bias_rd, prod_reg, neg_reg);
        bacc_we     = 1'b0;
        bacc_wa     = a_reg;
        bacc_wd     = '0;
        g_we        = 1'b0;
        x_we        = 1'b0;
        out_load    = 1'b0;
        out_kind_d  = KIND_FWD;
        out_index_d = 6'(a_reg);
        out_value_d = fwd_val;
        out_last_d  = (a_reg == A_LAST);

        case (state_reg)
            ST_CLEAR:
            begin
                wacc_we = 1'b1;
                bacc_we = (32'(k_reg) < NUM_OUT);
                bacc_wa = k_reg[OW-1:0];
                k_next  = k_reg + 1'b1;
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                a_next   = '0;
                b_next   = '0;
                k_next   = '0;
                sum_next = '0;
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (e.cmd)
                        CMD_WEIGHT:
                        begin
                            w_we = e.o_ok && e.i_ok;
                            w_wa = KW'(int'(e.out_index) * NUM_IN + int'(e.in_index));
                            w_wd = e.data_value;
                        end
                        CMD_BIAS:
                        begin
                            bias_we = e.o_ok;
                            bias_wa = e.out_index[OW-1:0];
                            bias_wd = e.data_value;
                        end
                        CMD_FWD:
                        begin
                            x_we = e.i_ok;
                            if (e.last_element)
                                state_next = ST_F_BIAS;
                        end
                        CMD_GRAD:
                        begin
                            g_we = e.o_ok;
                            if (e.last_element)
                                state_next = ST_G_RD;
                        end
                        CMD_STEP:
                        begin
                            state_next = ST_S_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_F_BIAS: state_next = ST_F_BLD;
            ST_F_BLD:
            begin
                sum_next   = 64'(bias_rd);
                state_next = ST_F_RD;
            end
            ST_F_RD:  state_next = ST_F_MUL;
            ST_F_MUL: state_next = ST_F_ACC;
            ST_F_ACC:
            begin
                sum_next = sum_reg + rounded;
                if (b_reg == B_LAST)
                    state_next = ST_F_OUT;
                else
                begin
                    b_next     = b_reg + 1'b1;
                    k_next     = k_reg + 1'b1;
                    state_next = ST_F_RD;
                end
            end
            ST_F_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (a_reg == A_LAST)
                        state_next = ST_IDLE;
                    else
                    begin
                        a_next     = a_reg + 1'b1;
                        k_next     = k_reg + 1'b1;
                        b_next     = '0;
                        state_next = ST_F_BIAS;
                    end
                end
            end
            ST_G_RD: state_next = ST_G_BW;
            ST_G_BW:
            begin
                bacc_we     = 1'b1;
                bacc_wd     = clamp32(64'(bacc_rd) + 64'(g_rd));
                g_hold_next = g_rd;
                b_next      = '0;
                state_next  = ST_G_XRD;
            end
            ST_G_XRD: state_next = ST_G_MUL;
            ST_G_MUL: state_next = ST_G_ACC;
            ST_G_ACC:
            begin
                wacc_we = 1'b1;
                wacc_wd = clamp32(64'(wacc_rd) + rounded);
                k_next  = k_reg + 1'b1;
                if (b_reg == B_LAST)
                begin
                    if (a_reg == A_LAST)
                    begin
                        a_next     = '0;
                        b_next     = '0;
                        k_next     = '0;
                        sum_next   = '0;
                        state_next = ST_H_RD;
                    end
                    else
                    begin
                        a_next     = a_reg + 1'b1;
                        state_next = ST_G_RD;
                    end
                end
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_G_XRD;
                end
            end
            ST_H_RD:  state_next = ST_H_MUL;
            ST_H_MUL: state_next = ST_H_ACC;
            ST_H_ACC:
            begin
                sum_next = sum_reg + rounded;
                if (a_reg == A_LAST)
                    state_next = ST_H_OUT;
                else
                begin
                    a_next     = a_reg + 1'b1;
                    k_next     = k_reg + K_STEP;
                    state_next = ST_H_RD;
                end
            end
            ST_H_OUT:
            begin
                out_kind_d  = KIND_GRAD;
                out_index_d = 6'(b_reg);
                out_value_d = clamp32(sum_reg);
                out_last_d  = (b_reg == B_LAST);
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (b_reg == B_LAST)
                        state_next = ST_IDLE;
                    else
                    begin
                        b_next     = b_reg + 1'b1;
                        a_next     = '0;
                        k_next     = KW'(b_reg) + 1'b1;
                        sum_next   = '0;
                        state_next = ST_H_RD;
                    end
                end
            end
            ST_S_RD:  state_next = ST_S_MUL;
            ST_S_MUL: state_next = ST_S_WR;
            ST_S_WR:
            begin
                w_we    = 1'b1;
                wacc_we = 1'b1;
                if (k_reg == K_LAST)
                begin
                    a_next     = '0;
                    state_next = ST_T_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_S_RD;
                end
            end
            ST_T_RD:  state_next = ST_T_MUL;
            ST_T_MUL: state_next = ST_T_WR;
            ST_T_WR:
            begin
                bias_we = 1'b1;
                bacc_we = 1'b1;
                if (a_reg == A_LAST)
                    state_next = ST_IDLE;
                else
                begin
                    a_next     = a_reg + 1'b1;
                    state_next = ST_T_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            k_reg     <= k_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rslt.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        g_hold_reg <= g_hold_next;
        if (out_load)
        begin
            out_kind_reg  <= out_kind_d;
            out_index_reg <= out_index_d;
            out_value_reg <= out_value_d;
            out_last_reg  <= out_last_d;
        end
    end

    assign clear_done        = (state_reg != ST_CLEAR);
    assign rslt.valid        = out_valid_reg;
    assign rslt.result_kind  = out_kind_reg;
    assign rslt.result_index = out_index_reg;
    assign rslt.result_value = out_value_reg;
    assign rslt.result_last  = out_last_reg;

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE && head.valid)
        else $error("queue popped outside idle");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_last_d |=> state_reg == ST_IDLE)
        else $error("run continued after last result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg || rslt.ready)
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- rtl/core/dense_layer_relu_sgd.sv -----
// ----------------------------------------------------------------------------
// dense_layer_relu_sgd
// Fully connected layer, Q16.16, with ReLU forward, backprop and SGD step.
//
// Items arrive on the item channel (valid/ready); an item transfers when both
// are high. Weight, bias and unmarked vector elements are stored and give no
// result. A forward element marked last emits NUM_OUT activations; a
// gradient element marked last updates the accumulators and emits NUM_IN
// input gradients. A step item applies the learning rate and clears the
// accumulators. Results leave through a registered result channel.
// Items pass through a 4-deep queue to one multiply-accumulate sequencer.
// After reset the accumulators are cleared with item ready low;
// configuration writes are taken at any time. A stalled result channel
// holds the sequencer while the queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_layer_relu_sgd
    import dlrs_pkg::*;
#(
    parameter int NUM_IN  = DEF_NUM_IN,
    parameter int NUM_OUT = DEF_NUM_OUT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dlrs_item_if.sink        item,
    dlrs_result_if.source    result,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic        relu_reg;
    logic [31:0] lr_reg;
    logic        pop;
    logic        clear_done;
    dlrs_head_t  head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relu_reg <= RELU_RESET;
            lr_reg   <= LR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RELU: relu_reg <= cfg_data[0];
                CFG_LR:   lr_reg   <= cfg_data;
                default:  lr_reg   <= lr_reg;
            endcase
        end
    end

    dlrs_front #(
        .NUM_IN  (NUM_IN),
        .NUM_OUT (NUM_OUT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .enable (clear_done),
        .pop    (pop),
        .head   (head)
    );

    dlrs_back #(
        .NUM_IN  (NUM_IN),
        .NUM_OUT (NUM_OUT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .clear_done    (clear_done),
        .relu_enable   (relu_reg),
        .learning_rate (lr_reg),
        .rslt          (result)
    );

endmodule

`default_nettype wire
